/* sv/gbei_pkg.sv */
package gbei_pkg;

   // Command codes of an input item.
   typedef enum logic [1:0] {
      CMD_READ   = 2'd0,
      CMD_WRITE  = 2'd1,
      CMD_BUTTON = 2'd2,
      CMD_NONE   = 2'd3
   } gbei_command_type;

   // Pads whose level comes from outside the register word.
   localparam logic [6:0] PAD_CARD_DETECT = 7'h47;
   localparam logic [6:0] PAD_KEY_DOWN    = 7'h4a;
   localparam logic [6:0] PAD_KEY_LEFT    = 7'h4b;

   // Bit positions inside a pad word.
   localparam int BIT_LEVEL = 2;
   localparam int BIT_MASK  = 4;
   localparam int BIT_CLEAR = 6;

   // Controller states.
   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } gbei_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic commit;
   } gbei_ctrl_type;

endpackage

/* sv/gbei_if.sv */
// Request channel: one bus access or button update per item.
interface gbei_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] command;
   logic [6:0] reg_index;
   logic [15:0] write_data;
   logic [1:0] button_mask;

   modport source (output valid, command, reg_index, write_data, button_mask, input ready);
   modport sink   (input valid, command, reg_index, write_data, button_mask, output ready);
endinterface

// Response channel: read data and interrupt level after each item.
interface gbei_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] read_data;
   logic        irq_level;

   modport source (output valid, read_data, irq_level, input ready);
   modport sink   (input valid, read_data, irq_level, output ready);
endinterface

// Configuration channel: card-present setting.
interface gbei_csr_if;
   logic valid;
   logic ready;
   logic card_inserted;

   modport source (output valid, card_inserted, input ready);
   modport sink   (input valid, card_inserted, output ready);
endinterface

/* sv/gbei_ctrl.sv */
module gbei_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output gbei_pkg::gbei_ctrl_type ctrl
);
   import gbei_pkg::*;

   gbei_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           out_free;

   // State and response-valid registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign out_free = !rsp_valid_ff || rsp_ready;

   // Next state and commands to the datapath.
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      ctrl         = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready    = 1'b1;
            ctrl.capture = req_valid;
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            // The item finishes once the output register can take its result.
            if (out_free) begin
               ctrl.commit  = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

/* sv/gbei_dp.sv */
module gbei_dp #(
   parameter int NUM_PADS = 128
) (
   input  logic                    clock,
   input  logic                    reset,
   input  gbei_pkg::gbei_ctrl_type ctrl,
   input  logic [1:0]              req_command,
   input  logic [6:0]              req_reg_index,
   input  logic [15:0]             req_write_data,
   input  logic [1:0]              req_button_mask,
   input  logic                    csr_we,
   input  logic                    csr_card_inserted,
   output logic [15:0]             rsp_read_data,
   output logic                    rsp_irq_level
);
   import gbei_pkg::*;

   localparam int AW = $clog2(NUM_PADS);
   localparam int CW = $clog2(NUM_PADS + 1);
   localparam int XW = (AW > 7) ? AW + 1 : 8;

   localparam logic [AW-1:0] ADDR_KEY_DOWN = AW'(PAD_KEY_DOWN);
   localparam logic [AW-1:0] ADDR_KEY_LEFT = AW'(PAD_KEY_LEFT);

   // Pad word memory with per-entry written flags.
   logic [15:0]         mem [NUM_PADS];
   logic [15:0]         mem_q_ff;
   logic [NUM_PADS-1:0] written_ff;
   logic                written_q_ff;

   // Edge state.
   logic [NUM_PADS-1:0] pending_ff, pending_in;
   logic                pend_q_ff;
   logic [CW-1:0]       active_cnt_ff, active_cnt_in;
   logic [1:0]          buttons_ff, buttons_in;
   logic [1:0]          key_mask_ff, key_mask_in;
   logic                card_ff;

   // Captured item.
   gbei_command_type    cmd_ff;
   logic [6:0]          idx_ff;
   logic [AW-1:0]       addr_ff;
   logic                in_range_ff;
   logic [15:0]         data_ff;
   logic [1:0]          btn_ff;

   // Output register.
   logic [15:0]         read_data_ff, read_data_in;
   logic                irq_ff, irq_in;

   logic [AW-1:0]       req_addr;
   logic                req_in_range;
   logic [15:0]         old_word;
   logic                is_cd, is_kd, is_kl;
   logic                do_write, do_button;
   logic                pend_old, pend_new, act_old, act_new, edge_hit;
   logic                fall_down, fall_left, inc_down, inc_left;
   logic [1:0]          inc_cnt;
   logic                dec_cnt;

   assign req_addr     = AW'(req_reg_index);
   assign req_in_range = XW'(req_reg_index) < XW'(NUM_PADS);

   // Capture the item at acceptance.
   always_ff @(posedge clock) begin
      if (ctrl.capture) begin
         cmd_ff      <= gbei_command_type'(req_command);
         idx_ff      <= req_reg_index;
         addr_ff     <= req_addr;
         in_range_ff <= req_in_range;
         data_ff     <= req_write_data;
         btn_ff      <= req_button_mask;
      end
   end

   // Memory read at capture, write at commit.
   always_ff @(posedge clock) begin
      if (ctrl.capture && req_in_range) begin
         mem_q_ff <= mem[req_addr];
      end
      if (ctrl.commit && do_write) begin
         mem[addr_ff] <= data_ff;
      end
   end

   // Written flags: an entry never written reads as zero. The addressed pad's
   // pending flag is read here too; it cannot change before the commit.
   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff   <= '0;
         written_q_ff <= 1'b0;
         pend_q_ff    <= 1'b0;
      end else begin
         if (ctrl.capture) begin
            written_q_ff <= req_in_range && written_ff[req_addr];
            pend_q_ff    <= req_in_range && pending_ff[req_addr];
         end
         if (ctrl.commit && do_write) begin
            written_ff[addr_ff] <= 1'b1;
         end
      end
   end

   assign old_word = written_q_ff ? mem_q_ff : 16'h0000;

   assign is_cd     = idx_ff == PAD_CARD_DETECT;
   assign is_kd     = idx_ff == PAD_KEY_DOWN;
   assign is_kl     = idx_ff == PAD_KEY_LEFT;
   assign do_write  = cmd_ff == CMD_WRITE && in_range_ff;
   assign do_button = cmd_ff == CMD_BUTTON;

   // Register write: an ordinary pad's level is its word's level bit, so only the
   // written pad can see a falling edge; external pads keep their level.
   always_comb begin
      pend_old = pend_q_ff;
      edge_hit = !(is_cd || is_kd || is_kl) && old_word[BIT_LEVEL]
                 && !data_ff[BIT_LEVEL] && !data_ff[BIT_MASK];
      pend_new = (pend_old && !data_ff[BIT_CLEAR]) || edge_hit;
      act_old  = pend_old && !old_word[BIT_MASK];
      act_new  = pend_new && !data_ff[BIT_MASK];
   end

   // Button change: a key pad falls when its button is newly pressed.
   assign fall_down = btn_ff[0] && !buttons_ff[0] && !key_mask_ff[0];
   assign fall_left = btn_ff[1] && !buttons_ff[1] && !key_mask_ff[1];
   assign inc_down  = do_button && fall_down && !pending_ff[ADDR_KEY_DOWN];
   assign inc_left  = do_button && fall_left && !pending_ff[ADDR_KEY_LEFT];

   // Count of pending unmasked pads; the interrupt is this count being nonzero.
   always_comb begin
      inc_cnt = 2'(inc_down) + 2'(inc_left) + 2'(do_write && act_new && !act_old);
      dec_cnt = do_write && act_old && !act_new;
      active_cnt_in = active_cnt_ff + CW'(inc_cnt) - CW'(dec_cnt);
   end

   // Pending flags, buttons and key mask bits.
   always_comb begin
      pending_in  = pending_ff;
      buttons_in  = buttons_ff;
      key_mask_in = key_mask_ff;
      if (do_write) begin
         pending_in[addr_ff] = pend_new;
         if (is_kd) begin
            key_mask_in[0] = data_ff[BIT_MASK];
         end
         if (is_kl) begin
            key_mask_in[1] = data_ff[BIT_MASK];
         end
      end
      if (do_button) begin
         buttons_in = btn_ff;
         if (fall_down) begin
            pending_in[ADDR_KEY_DOWN] = 1'b1;
         end
         if (fall_left) begin
            pending_in[ADDR_KEY_LEFT] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff    <= '0;
         active_cnt_ff <= '0;
         buttons_ff    <= '0;
         key_mask_ff   <= '0;
      end else if (ctrl.commit) begin
         pending_ff    <= pending_in;
         active_cnt_ff <= active_cnt_in;
         buttons_ff    <= buttons_in;
         key_mask_ff   <= key_mask_in;
      end
   end

   // Card-present setting.
   always_ff @(posedge clock) begin
      if (reset) begin
         card_ff <= 1'b0;
      end else if (csr_we) begin
         card_ff <= csr_card_inserted;
      end
   end

   // Read data with the active-low level of the external pads patched in.
   always_comb begin
      read_data_in = 16'h0000;
      if (cmd_ff == CMD_READ && in_range_ff) begin
         read_data_in = old_word;
         if (is_cd) begin
            read_data_in[BIT_LEVEL] = !card_ff;
         end
         if (is_kd) begin
            read_data_in[BIT_LEVEL] = !buttons_ff[0];
         end
         if (is_kl) begin
            read_data_in[BIT_LEVEL] = !buttons_ff[1];
         end
      end
      irq_in = active_cnt_in != '0;
   end

   always_ff @(posedge clock) begin
      if (ctrl.commit) begin
         read_data_ff <= read_data_in;
         irq_ff       <= irq_in;
      end
   end

   assign rsp_read_data = read_data_ff;
   assign rsp_irq_level = irq_ff;

endmodule

/* sv/gpio_bank_edge_interrupt_top.sv */
// Bank of 16-bit pad registers with falling-edge interrupts. Each request item
// reads a pad word, writes one (bit 6 of the word clears that pad's pending
// flag), or sets the held buttons; each gives exactly one response item with the
// read data (zero unless a read) and the interrupt level after the item. The
// card-detect pad and the two key pads report an active-low level in bit 2,
// taken from the card-present setting and the held buttons. An item first does
// the registered read of the pad-word memory and then the update and write-back;
// a response not yet taken holds the update step. A new item is accepted while
// a finished response still waits. The interrupt comes from a count of pending
// unmasked pads kept beside the pending flags. No clearing pass follows reset.
// The card-present setting may be written at any time the bank is idle and is
// taken in the same cycle.
module gpio_bank_edge_interrupt_top #(
   parameter int NUM_PADS = 128
) (
   input logic        clock,
   input logic        reset,
   gbei_req_if.sink   req,
   gbei_rsp_if.source rsp,
   gbei_csr_if.sink   csr
);
   import gbei_pkg::*;

   gbei_ctrl_type ctrl;

   assign csr.ready = 1'b1;

   // Sequencing of each item.
   gbei_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .ctrl      (ctrl)
   );

   // Pad words, pending flags and interrupt count.
   gbei_dp #(
      .NUM_PADS (NUM_PADS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .ctrl              (ctrl),
      .req_command       (req.command),
      .req_reg_index     (req.reg_index),
      .req_write_data    (req.write_data),
      .req_button_mask   (req.button_mask),
      .csr_we            (csr.valid && csr.ready),
      .csr_card_inserted (csr.card_inserted),
      .rsp_read_data     (rsp.read_data),
      .rsp_irq_level     (rsp.irq_level)
   );

`ifndef SYNTHESIS
   // An accepted item keeps the bank busy in the next cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready |=> !req.ready)
      else $error("item accepted in back-to-back cycles");

   // A response appears only out of the busy cycle of an item.
   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp.valid) |-> !$past(req.ready))
      else $error("response raised without an item in progress");

   // Reset leaves no response pending.
   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp.valid)
      else $error("response valid after reset");
`endif

endmodule
